// ===== hw/rtl/slt_pkg.sv =====
package slt_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned OpW    = 2;
  localparam int unsigned StatW  = 3;
  localparam int unsigned OccW   = 5;

  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_SEARCH = 2'd1;
  localparam logic [OpW-1:0] OP_DELETE = 2'd2;

  localparam logic [StatW-1:0] ST_INSERTED = 3'd0;
  localparam logic [StatW-1:0] ST_FULL     = 3'd1;
  localparam logic [StatW-1:0] ST_FOUND    = 3'd2;
  localparam logic [StatW-1:0] ST_ABSENT   = 3'd3;
  localparam logic [StatW-1:0] ST_DELETED  = 3'd4;
  localparam logic [StatW-1:0] ST_DEL_MISS = 3'd5;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                     ins_en;
    logic                     del_en;
    logic signed [ValueW-1:0] value;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/slt_cell.sv =====
module slt_cell
  import slt_pkg::*;
(
  input  logic                     clk_i,
  input  cell_cmd_t                cmd_i,
  input  logic                     in_use_i,
  input  logic                     left_lt_i,
  input  logic signed [ValueW-1:0] left_entry_i,
  input  logic signed [ValueW-1:0] right_entry_i,
  output logic signed [ValueW-1:0] entry_o,
  output logic                     lt_o,
  output logic                     head_eq_o
);

  logic signed [ValueW-1:0] entry_q, entry_d;

  assign lt_o      = in_use_i && (entry_q < cmd_i.value);
  // first equal entry: everything to the left is smaller
  assign head_eq_o = in_use_i && (entry_q == cmd_i.value) && left_lt_i;
  assign entry_o   = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins_en && !lt_o) begin
      entry_d = left_lt_i ? cmd_i.value : left_entry_i;
    end else if (cmd_i.del_en && !lt_o) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== hw/rtl/sorted_list_table.sv =====
// Sorted table of up to CAPACITY signed 32-bit values, kept in ascending
// order in a row of compare-and-shift cells, one value per cell. Every cell
// compares its value against the broadcast operand in the cycle a word is
// accepted and shifts left or right by one place to carry out an insert, a
// search or a delete. A new word can be accepted every cycle as long
// as the receiver takes each result word when it is offered. The result word
// appears in the output register in the cycle after the input word is accepted.
// While that word waits untaken, the input side stalls; it accepts again in
// the cycle the result word is taken. Equal values are all kept. An insert
// into a full table and a delete of a missing value leave the table untouched,
// and the status reports it. Unused entries never take part in a comparison,
// so no clearing is needed after reset.
module sorted_list_table
  import slt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] value
  input  logic [1:0]  s_axis_tuser,  // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [4:0] occupancy, [7:5] zero
  output logic [2:0]  m_axis_tuser   // [2:0] status
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic [StatW-1:0] status_q, status_d;
  logic [OccW-1:0]  occ_q;
  logic [31:0]      count_ext;

  logic signed [ValueW-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]      lt;
  logic [CAPACITY-1:0]      hit;
  logic [CAPACITY-1:0]      in_use;

  cell_cmd_t cmd;
  logic      acc, full, found;

  assign acc   = s_axis_tvalid && s_axis_tready;
  assign full  = (count_q == CntW'(CAPACITY));
  assign found = |hit;

  assign cmd.value  = s_axis_tdata;
  assign cmd.ins_en = acc && (s_axis_tuser == OP_INSERT) && !full;
  assign cmd.del_en = acc && (s_axis_tuser == OP_DELETE) && found;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic                     left_lt;
    logic signed [ValueW-1:0] left_entry, right_entry;

    assign in_use[k] = (CntW'(k) < count_q);

    if (k == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_entry = '0;
    end else begin : g_body
      assign left_lt    = lt[k-1];
      assign left_entry = entry[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_mid
      assign right_entry = entry[k+1];
    end

    slt_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .in_use_i     (in_use[k]),
      .left_lt_i    (left_lt),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .entry_o      (entry[k]),
      .lt_o         (lt[k]),
      .head_eq_o    (hit[k])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_ABSENT;
    case (s_axis_tuser)
      OP_INSERT: begin
        status_d = full ? ST_FULL : ST_INSERTED;
        if (cmd.ins_en) count_d = count_q + CntW'(1);
      end
      OP_SEARCH: status_d = found ? ST_FOUND : ST_ABSENT;
      OP_DELETE: begin
        status_d = found ? ST_DELETED : ST_DEL_MISS;
        if (cmd.del_en) count_d = count_q - CntW'(1);
      end
      default: status_d = ST_ABSENT;
    endcase
  end

  assign count_ext = 32'(count_d);

  // output word register; a taken word frees the slot in the same cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      status_q <= status_d;
      occ_q    <= count_ext[OccW-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, occ_q};
  assign m_axis_tuser  = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> $stable(count_q))
    else $error("entry count changed without an accepted word");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> m_axis_tvalid)
    else $error("no result word after an accepted word");

  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.del_en |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("delete did not shrink the table");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins_en |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not grow the table");

endmodule
